>>> hw/rtl/rtsc_pkg.sv
// Shared constants, types and state codes for the tile slot cache.
`timescale 1ns / 1ps
package rtsc_pkg;
   localparam int PLANE_W   = 64;
   localparam int PLANE_H   = 32;
   localparam int MAX_TILES = 2048;
   localparam int XW        = $clog2(PLANE_W);
   localparam int YW        = $clog2(PLANE_H);
   localparam int CELLS     = PLANE_W * PLANE_H;
   localparam int CW        = $clog2(CELLS);
   localparam int TW        = $clog2(MAX_TILES);
   localparam int EW        = TW + 1;
   localparam int SWEEP_LEN = (CELLS > MAX_TILES) ? CELLS : MAX_TILES;
   localparam int SCW       = $clog2(SWEEP_LEN);
   localparam logic [EW-1:0] REF_MAX = {EW{1'b1}};

   localparam logic FUNC_INIT  = 1'b0;
   localparam logic FUNC_PATCH = 1'b1;

   localparam logic [1:0] CSR_VRAM_BASE = 2'd0;
   localparam logic [1:0] CSR_ACTIVE    = 2'd1;
   localparam logic [1:0] CSR_RESERVED  = 2'd2;
   localparam logic [1:0] CSR_TOTAL     = 2'd3;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOK,
      ST_READ2,
      ST_REL,
      ST_CLM,
      ST_DONE
   } state_type;
endpackage

>>> hw/rtl/rtsc_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module rtsc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> hw/rtl/refcounted_tile_slot_cache_top.sv
// Top level: tile slot cache sequencer over five table memories.
//
//   channel | dir | payload
//   req_    | in  | tdata: tile_word, first_in_run, start_x, start_y, column_mode
//           |     | tuser: func, tlast: last_in_run
//   rsp_    | out | tdata: patched_word, load_request, load_tile_index,
//           |     | load_target, load_count, alloc_failed; tlast: run_done
//   csr_    | in  | we, index, wdata (12 bits)
//
// A patch beat ends after ST_REL when the cell keeps its slot and after ST_CLM
// when it claims one (pass-through goes to ST_DONE): read cell map, then reverse
// map and count, then release, then claim, chained through the registered reads.
// An init beat sweeps all 2048 entries (one a cycle).
// After reset the same clearing sweep runs with req_tready low.
// A result waits in its register while rsp_tready is low; the next beat can
// be taken meanwhile, but its own result then waits for the register.
`timescale 1ns / 1ps
module refcounted_tile_slot_cache_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] tile_word, [16] first_in_run, [32:17] start_x, [48:33] start_y,
   // [49] column_mode, [55:50] zero
   input  logic [55:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] patched_word, [16] load_request, [27:17] load_tile_index,
   // [39:28] load_target, [51:40] load_count, [52] alloc_failed, [55:53] zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   localparam int TW  = rtsc_pkg::TW;
   localparam int EW  = rtsc_pkg::EW;
   localparam int CW  = rtsc_pkg::CW;
   localparam int XW  = rtsc_pkg::XW;
   localparam int YW  = rtsc_pkg::YW;
   localparam int SCW = rtsc_pkg::SCW;

   rtsc_pkg::state_type state_ff, state_in;

   logic [TW-1:0] vram_base_ff, vram_base_in;
   logic [EW-1:0] active_ff, active_in, reserved_ff, reserved_in, total_ff, total_in;
   logic [XW-1:0] cursor_x_ff, cursor_x_in;
   logic [YW-1:0] cursor_y_ff, cursor_y_in;
   logic          col_ff, col_in, pass_ff, pass_in;
   logic [EW-1:0] fc_ff, fc_in;
   logic [SCW-1:0] sweep_i_ff, sweep_i_in;
   logic          sweep_rsp_ff, sweep_rsp_in;
   logic [EW-1:0] pin_lim_ff, pin_lim_in, free_n_ff, free_n_in, act_c_ff, act_c_in;
   logic [15:0]   word_ff, word_in;
   logic [TW-1:0] tile_ff, tile_in;
   logic [CW-1:0] cell_ff, cell_in;
   logic [EW-1:0] old_ff, old_in, tts_ff, tts_in;
   logic          pushed_ff, pushed_in;
   logic [15:0]   res_word_ff, res_word_in;
   logic          res_req_ff, res_req_in, res_fail_ff, res_fail_in, res_last_ff, res_last_in;
   logic [TW-1:0] res_ltile_ff, res_ltile_in;
   logic [EW-1:0] res_ltarget_ff, res_ltarget_in, res_lcount_ff, res_lcount_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0]   rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tlast_ff, rsp_tlast_in;

   // memory ports
   logic          refs_we, t2s_we, s2t_we, free_we, cell_we;
   logic [TW-1:0] refs_wa, t2s_wa, s2t_wa, free_wa, refs_ra, t2s_ra, s2t_ra, free_ra;
   logic [CW-1:0] cell_wa, cell_ra;
   logic [EW-1:0] refs_wd, t2s_wd, s2t_wd, cell_wd, refs_rd, t2s_rd, s2t_rd, cell_rd;
   logic [TW-1:0] free_wd, free_rd;

   rtsc_ram #(.WIDTH(EW), .DEPTH(rtsc_pkg::MAX_TILES)) u_refs (
      .clock(clock), .we(refs_we), .waddr(refs_wa), .wdata(refs_wd),
      .raddr(refs_ra), .rdata(refs_rd));
   rtsc_ram #(.WIDTH(EW), .DEPTH(rtsc_pkg::MAX_TILES)) u_t2s (
      .clock(clock), .we(t2s_we), .waddr(t2s_wa), .wdata(t2s_wd),
      .raddr(t2s_ra), .rdata(t2s_rd));
   rtsc_ram #(.WIDTH(EW), .DEPTH(rtsc_pkg::MAX_TILES)) u_s2t (
      .clock(clock), .we(s2t_we), .waddr(s2t_wa), .wdata(s2t_wd),
      .raddr(s2t_ra), .rdata(s2t_rd));
   rtsc_ram #(.WIDTH(TW), .DEPTH(rtsc_pkg::MAX_TILES)) u_free (
      .clock(clock), .we(free_we), .waddr(free_wa), .wdata(free_wd),
      .raddr(free_ra), .rdata(free_rd));
   rtsc_ram #(.WIDTH(EW), .DEPTH(rtsc_pkg::CELLS)) u_cell (
      .clock(clock), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
      .raddr(cell_ra), .rdata(cell_rd));

   logic req_acc, out_free, sweep_last;
   assign req_tready = (state_ff == rtsc_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign sweep_last = (sweep_i_ff == SCW'(rtsc_pkg::SWEEP_LEN - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtsc_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = sweep_rsp_ff ? rtsc_pkg::ST_DONE : rtsc_pkg::ST_IDLE;
            end
         end
         rtsc_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == rtsc_pkg::FUNC_INIT) begin
                  state_in = rtsc_pkg::ST_SWEEP;
               end else if (pass_ff) begin
                  state_in = rtsc_pkg::ST_DONE;
               end else begin
                  state_in = rtsc_pkg::ST_LOOK;
               end
            end
         end
         rtsc_pkg::ST_LOOK:  state_in = rtsc_pkg::ST_READ2;
         rtsc_pkg::ST_READ2: state_in = rtsc_pkg::ST_REL;
         rtsc_pkg::ST_REL: begin
            if (!old_ff[TW] && s2t_rd == {1'b0, tile_ff}) begin
               state_in = rtsc_pkg::ST_DONE;
            end else begin
               state_in = rtsc_pkg::ST_CLM;
            end
         end
         rtsc_pkg::ST_CLM: state_in = rtsc_pkg::ST_DONE;
         rtsc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rtsc_pkg::ST_IDLE;
            end
         end
         default: state_in = rtsc_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic          cc;
   logic [EW-1:0] act_c, rsv_c, tot_c, pin_c, slot_sum, rel_dec;
   logic [TW-1:0] slot_c;
   logic          rel_ok, claim_load, claim_fail, pin_i;

   always_comb begin
      vram_base_in = vram_base_ff;
      active_in    = active_ff;
      reserved_in  = reserved_ff;
      total_in     = total_ff;
      if (csr_we) begin
         unique case (csr_index)
            rtsc_pkg::CSR_VRAM_BASE: vram_base_in = csr_wdata[TW-1:0];
            rtsc_pkg::CSR_ACTIVE:    active_in    = csr_wdata;
            rtsc_pkg::CSR_RESERVED:  reserved_in  = csr_wdata;
            rtsc_pkg::CSR_TOTAL:     total_in     = csr_wdata;
            default: ;
         endcase
      end

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      col_in      = col_ff;
      pass_in     = pass_ff;
      fc_in       = fc_ff;
      sweep_i_in  = sweep_i_ff;
      sweep_rsp_in = sweep_rsp_ff;
      pin_lim_in  = pin_lim_ff;
      free_n_in   = free_n_ff;
      act_c_in    = act_c_ff;
      word_in     = word_ff;
      tile_in     = tile_ff;
      cell_in     = cell_ff;
      old_in      = old_ff;
      tts_in      = tts_ff;
      pushed_in   = pushed_ff;
      res_word_in    = res_word_ff;
      res_req_in     = res_req_ff;
      res_fail_in    = res_fail_ff;
      res_last_in    = res_last_ff;
      res_ltile_in   = res_ltile_ff;
      res_ltarget_in = res_ltarget_ff;
      res_lcount_in  = res_lcount_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tlast_in   = rsp_tlast_ff;

      refs_we = 1'b0; refs_wa = '0; refs_wd = '0; refs_ra = '0;
      t2s_we  = 1'b0; t2s_wa  = '0; t2s_wd  = '0; t2s_ra  = '0;
      s2t_we  = 1'b0; s2t_wa  = '0; s2t_wd  = '0; s2t_ra  = '0;
      free_we = 1'b0; free_wa = '0; free_wd = '0; free_ra = '0;
      cell_we = 1'b0; cell_wa = '0; cell_wd = '0; cell_ra = '0;

      cx = req_tdata[16] ? req_tdata[17 +: XW] : cursor_x_ff;
      cy = req_tdata[16] ? req_tdata[33 +: YW] : cursor_y_ff;
      cc = req_tdata[16] ? req_tdata[49] : col_ff;
      act_c = (active_ff > EW'(rtsc_pkg::MAX_TILES)) ? EW'(rtsc_pkg::MAX_TILES) : active_ff;
      rsv_c = (reserved_ff > EW'(rtsc_pkg::MAX_TILES)) ? EW'(rtsc_pkg::MAX_TILES) : reserved_ff;
      tot_c = (total_ff > EW'(rtsc_pkg::MAX_TILES)) ? EW'(rtsc_pkg::MAX_TILES) : total_ff;
      pin_c = (rsv_c < tot_c) ? rsv_c : tot_c;
      pin_i = 32'(sweep_i_ff) < 32'(pin_lim_ff);
      rel_ok = !old_ff[TW] && !(old_ff < reserved_ff) && (refs_rd != '0);
      rel_dec = refs_rd - EW'(1);
      slot_c = '0;
      claim_load = 1'b0;
      claim_fail = 1'b0;
      slot_sum = '0;

      unique case (state_ff)
         rtsc_pkg::ST_SWEEP: begin
            sweep_i_in = sweep_i_ff + SCW'(1);
            if (32'(sweep_i_ff) < 32'(rtsc_pkg::MAX_TILES)) begin
               refs_we = 1'b1;
               refs_wa = sweep_i_ff[TW-1:0];
               refs_wd = pin_i ? EW'(1) : '0;
               t2s_we  = 1'b1;
               t2s_wa  = sweep_i_ff[TW-1:0];
               t2s_wd  = pin_i ? {1'b0, sweep_i_ff[TW-1:0]} : {1'b1, {TW{1'b0}}};
               s2t_we  = 1'b1;
               s2t_wa  = sweep_i_ff[TW-1:0];
               s2t_wd  = t2s_wd;
               free_we = 32'(sweep_i_ff) < 32'(free_n_ff);
               free_wa = sweep_i_ff[TW-1:0];
               free_wd = act_c_ff[TW-1:0] - TW'(1) - sweep_i_ff[TW-1:0];
            end
            if (32'(sweep_i_ff) < 32'(rtsc_pkg::CELLS)) begin
               cell_we = 1'b1;
               cell_wa = sweep_i_ff[CW-1:0];
               cell_wd = {1'b1, {TW{1'b0}}};
            end
         end
         rtsc_pkg::ST_IDLE: begin
            if (req_acc) begin
               word_in = req_tdata[15:0];
               res_last_in = req_tlast;
               res_ltile_in = '0;
               res_fail_in  = 1'b0;
               if (req_tuser == rtsc_pkg::FUNC_INIT) begin
                  cursor_x_in = '0;
                  cursor_y_in = '0;
                  col_in      = 1'b0;
                  pass_in     = active_ff >= total_ff;
                  sweep_i_in  = '0;
                  sweep_rsp_in = 1'b1;
                  act_c_in    = act_c;
                  if (active_ff >= total_ff) begin
                     pin_lim_in = '0;
                     free_n_in  = '0;
                  end else begin
                     pin_lim_in = pin_c;
                     free_n_in  = (act_c > rsv_c) ? act_c - rsv_c : '0;
                  end
                  fc_in = free_n_in;
                  res_word_in    = '0;
                  res_req_in     = (active_ff >= total_ff) || (reserved_ff != '0);
                  res_ltarget_in = res_req_in ? {1'b0, vram_base_ff} : '0;
                  res_lcount_in  = (active_ff >= total_ff) ? total_ff :
                                   ((reserved_ff != '0) ? reserved_ff : '0);
               end else begin
                  col_in      = cc;
                  cursor_x_in = cc ? cx : cx + XW'(1);
                  cursor_y_in = cc ? cy + YW'(1) : cy;
                  tile_in     = req_tdata[TW-1:0] - vram_base_ff;
                  cell_in     = CW'({cx, cy});
                  res_word_in    = req_tdata[15:0];
                  res_req_in     = 1'b0;
                  res_ltarget_in = '0;
                  res_lcount_in  = '0;
               end
            end
         end
         rtsc_pkg::ST_LOOK: begin
            cell_ra = cell_ff;
            t2s_ra  = tile_ff;
         end
         rtsc_pkg::ST_READ2: begin
            old_in  = cell_rd;
            tts_in  = t2s_rd;
            s2t_ra  = cell_rd[TW-1:0];
            refs_ra = cell_rd[TW-1:0];
         end
         rtsc_pkg::ST_REL: begin
            refs_ra   = tts_ff[TW-1:0];
            free_ra   = fc_ff[TW-1:0] - TW'(1);
            pushed_in = 1'b0;
            if (!old_ff[TW] && s2t_rd == {1'b0, tile_ff}) begin
               slot_sum = EW'(vram_base_ff) + EW'(old_ff[TW-1:0]);
               res_word_in = {word_ff[15:TW], slot_sum[TW-1:0]};
            end else if (rel_ok) begin
               refs_we = 1'b1;
               refs_wa = old_ff[TW-1:0];
               refs_wd = rel_dec;
               if (rel_dec == '0) begin
                  t2s_we = !s2t_rd[TW];
                  t2s_wa = s2t_rd[TW-1:0];
                  t2s_wd = {1'b1, {TW{1'b0}}};
                  s2t_we = 1'b1;
                  s2t_wa = old_ff[TW-1:0];
                  s2t_wd = {1'b1, {TW{1'b0}}};
                  if (fc_ff < EW'(rtsc_pkg::MAX_TILES)) begin
                     free_we   = 1'b1;
                     free_wa   = fc_ff[TW-1:0];
                     free_wd   = old_ff[TW-1:0];
                     fc_in     = fc_ff + EW'(1);
                     pushed_in = 1'b1;
                  end
               end
            end
         end
         rtsc_pkg::ST_CLM: begin
            priority if ({1'b0, tile_ff} < reserved_ff) begin
               slot_c = tile_ff;
            end else if (!({1'b0, tile_ff} < total_ff)) begin
               claim_fail = 1'b1;
            end else if (!tts_ff[TW]) begin
               slot_c  = tts_ff[TW-1:0];
               refs_we = 1'b1;
               refs_wa = tts_ff[TW-1:0];
               refs_wd = (refs_rd == rtsc_pkg::REF_MAX) ? rtsc_pkg::REF_MAX
                                                        : refs_rd + EW'(1);
            end else if (fc_ff == '0) begin
               claim_fail = 1'b1;
            end else begin
               slot_c     = pushed_ff ? old_ff[TW-1:0] : free_rd;
               claim_load = 1'b1;
               fc_in      = fc_ff - EW'(1);
               t2s_we = 1'b1; t2s_wa = tile_ff; t2s_wd = {1'b0, slot_c};
               s2t_we = 1'b1; s2t_wa = slot_c;  s2t_wd = {1'b0, tile_ff};
               refs_we = 1'b1; refs_wa = slot_c; refs_wd = EW'(1);
            end
            cell_we = 1'b1;
            cell_wa = cell_ff;
            cell_wd = {1'b0, slot_c};
            slot_sum = EW'(vram_base_ff) + EW'(slot_c);
            res_word_in    = {word_ff[15:TW], slot_sum[TW-1:0]};
            res_fail_in    = claim_fail;
            res_req_in     = claim_load;
            res_ltile_in   = claim_load ? tile_ff : '0;
            res_ltarget_in = claim_load ? slot_sum : '0;
            res_lcount_in  = claim_load ? EW'(1) : '0;
         end
         rtsc_pkg::ST_DONE: begin
            sweep_rsp_in = 1'b0;
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {3'b000, res_fail_ff, res_lcount_ff, res_ltarget_ff,
                                res_ltile_ff, res_req_ff, res_word_ff};
               rsp_tlast_in  = res_last_ff;
            end
         end
         default: ;
      endcase

      if (state_ff != rtsc_pkg::ST_DONE && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtsc_pkg::ST_SWEEP;
         vram_base_ff  <= '0;
         active_ff     <= '0;
         reserved_ff   <= '0;
         total_ff      <= '0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         col_ff        <= 1'b0;
         pass_ff       <= 1'b0;
         fc_ff         <= '0;
         sweep_i_ff    <= '0;
         sweep_rsp_ff  <= 1'b0;
         pin_lim_ff    <= '0;
         free_n_ff     <= '0;
         act_c_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vram_base_ff  <= vram_base_in;
         active_ff     <= active_in;
         reserved_ff   <= reserved_in;
         total_ff      <= total_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         col_ff        <= col_in;
         pass_ff       <= pass_in;
         fc_ff         <= fc_in;
         sweep_i_ff    <= sweep_i_in;
         sweep_rsp_ff  <= sweep_rsp_in;
         pin_lim_ff    <= pin_lim_in;
         free_n_ff     <= free_n_in;
         act_c_ff      <= act_c_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      tile_ff        <= tile_in;
      cell_ff        <= cell_in;
      old_ff         <= old_in;
      tts_ff         <= tts_in;
      pushed_ff      <= pushed_in;
      res_word_ff    <= res_word_in;
      res_req_ff     <= res_req_in;
      res_fail_ff    <= res_fail_in;
      res_last_ff    <= res_last_in;
      res_ltile_ff   <= res_ltile_in;
      res_ltarget_ff <= res_ltarget_in;
      res_lcount_ff  <= res_lcount_in;
      rsp_tdata_ff   <= rsp_tdata_in;
      rsp_tlast_ff   <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= EW'(rtsc_pkg::MAX_TILES))
      else $error("free count overflow");

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtsc_pkg::ST_SWEEP) |-> !req_tready)
      else $error("beat taken during table sweep");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[16]) |-> (rsp_tdata[51:17] == '0))
      else $error("load fields set without load request");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtsc_pkg::ST_DONE && rsp_tvalid && !rsp_tready)
      |=> (state_ff == rtsc_pkg::ST_DONE))
      else $error("result dropped while output stalled");
endmodule
